FILE: src/v2py_pkg.sv
// Shared types, constants and the arctangent table for the vector to pitch/yaw pipeline.
// No dependencies; every other file in src imports this package.
package v2py_pkg;

    localparam int CORDIC_STEPS_DEF = 20;
    localparam int TAB_LEN          = 32;

    localparam int IN_W    = 32;
    localparam int OUT_W   = 25;
    localparam int FRAC_SH = 24;
    localparam int CW      = 59;
    localparam int AW      = 34;
    localparam int SQ_W    = 64;
    localparam int RT_W    = 32;
    localparam int SH_W    = 5;
    localparam int Q_W     = 27;
    localparam int RND_SH  = 8;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 56;

    localparam logic signed [AW-1:0]  HALF_TURN_Q24   = 34'sd3019898880;
    localparam logic signed [AW-1:0]  ROUND_HALF      = 34'sd128;
    localparam logic signed [Q_W-1:0] FULL_TURN_Q16   = 27'sd23592960;
    localparam logic [OUT_W-1:0]      RIGHT_Q16       = 25'd5898240;
    localparam logic [OUT_W-1:0]      THREE_RIGHT_Q16 = 25'd17694720;

    typedef struct packed {
        logic                   zero_xy;
        logic                   z_pos;
        logic signed [IN_W-1:0] xs;
        logic signed [IN_W-1:0] ys;
        logic signed [IN_W-1:0] zs;
    } v2py_vec_t;

    typedef struct packed {
        logic                 hold;
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [AW-1:0] ang;
    } v2py_rot_t;

    typedef struct packed {
        logic      zero_xy;
        logic      z_pos;
        v2py_rot_t yaw;
        v2py_rot_t pitch;
    } v2py_cst_t;

    // atan(2^-i) in degrees, scaled by 2^24
    function automatic logic signed [AW-1:0] atan_q24(input int unsigned idx);
        case (idx)
            0:  return 34'sd754974720;
            1:  return 34'sd445687602;
            2:  return 34'sd235489088;
            3:  return 34'sd119537938;
            4:  return 34'sd60000934;
            5:  return 34'sd30029717;
            6:  return 34'sd15018523;
            7:  return 34'sd7509720;
            8:  return 34'sd3754917;
            9:  return 34'sd1877466;
            10: return 34'sd938734;
            11: return 34'sd469367;
            12: return 34'sd234684;
            13: return 34'sd117342;
            14: return 34'sd58671;
            15: return 34'sd29335;
            16: return 34'sd14668;
            17: return 34'sd7334;
            18: return 34'sd3667;
            19: return 34'sd1833;
            20: return 34'sd917;
            21: return 34'sd458;
            22: return 34'sd229;
            23: return 34'sd115;
            24: return 34'sd57;
            25: return 34'sd29;
            26: return 34'sd14;
            27: return 34'sd7;
            28: return 34'sd4;
            29: return 34'sd2;
            30: return 34'sd1;
            default: return '0;
        endcase
    endfunction

endpackage

FILE: src/vector_to_pitch_yaw.sv
// Stages from input beat to output beat:
// 6 front stages, 32 square root stages, one stage per CORDIC micro-rotation, one output stage.
// Throughput: one beat per cycle; a skid beat at the output lets one more beat enter on a stall.
// Reset (aresetn low, synchronous) clears all valid bits; the block keeps no other state.
module vector_to_pitch_yaw import v2py_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // x_coord[31:0], y_coord[63:32], z_coord[95:64]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // pitch_deg[24:0], yaw_deg[49:25], zero pad
);

    logic            en;
    logic            p_vld, q_vld, c_vld;
    v2py_vec_t       p_vec, q_vec;
    logic [SQ_W-1:0] p_sum;
    logic [RT_W-1:0] q_h;
    v2py_cst_t       c_cst;

    assign s_tready = en;

    v2py_prep u_prep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (s_tvalid),
        .x_in    ($signed(s_tdata[IN_W-1:0])),
        .y_in    ($signed(s_tdata[2*IN_W-1:IN_W])),
        .z_in    ($signed(s_tdata[3*IN_W-1:2*IN_W])),
        .vld_out (p_vld),
        .vec_out (p_vec),
        .sum_out (p_sum)
    );

    v2py_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (p_vld),
        .vec_in  (p_vec),
        .sum_in  (p_sum),
        .vld_out (q_vld),
        .vec_out (q_vec),
        .h_out   (q_h)
    );

    v2py_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (q_vld),
        .vec_in  (q_vec),
        .h_in    (q_h),
        .vld_out (c_vld),
        .cst_out (c_cst)
    );

    v2py_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .vld_in   (c_vld),
        .cst_in   (c_cst),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: src/v2py_prep.sv
// Front stages: input register, peak magnitude, normalizing shift, scaling, squares, sum.
// Depends on v2py_pkg.
module v2py_prep import v2py_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   vld_in,
    input  logic signed [IN_W-1:0] x_in,
    input  logic signed [IN_W-1:0] y_in,
    input  logic signed [IN_W-1:0] z_in,
    output logic                   vld_out,
    output v2py_vec_t              vec_out,
    output logic [SQ_W-1:0]        sum_out
);

    logic                   v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [IN_W-1:0] x0_reg, y0_reg, z0_reg;
    logic signed [IN_W-1:0] x1_reg, y1_reg, z1_reg;
    logic signed [IN_W-1:0] x2_reg, y2_reg, z2_reg;
    logic                   zxy1_reg, zp1_reg, zxy2_reg, zp2_reg;
    logic [IN_W-1:0]        m1_reg;
    logic [SH_W-1:0]        sh2_reg;
    v2py_vec_t              vec3_reg, vec4_reg, vec5_reg;
    logic [SQ_W-1:0]        sqx4_reg, sqy4_reg, sum5_reg;

    logic [IN_W-1:0]        ax, ay, az, m1_next;
    logic [SH_W-1:0]        sh2_next;
    v2py_vec_t              vec3_next;
    logic signed [SQ_W-1:0] px, py;

    always_comb begin
        ax = x0_reg[IN_W-1] ? IN_W'(-x0_reg) : IN_W'(x0_reg);
        ay = y0_reg[IN_W-1] ? IN_W'(-y0_reg) : IN_W'(y0_reg);
        az = z0_reg[IN_W-1] ? IN_W'(-z0_reg) : IN_W'(z0_reg);
        m1_next = ax;
        if (ay > m1_next) begin
            m1_next = ay;
        end
        if (az > m1_next) begin
            m1_next = az;
        end
    end

    always_comb begin
        sh2_next = '0;
        for (int k = 0; k < IN_W - 1; k++) begin
            if (m1_reg[k]) begin
                sh2_next = SH_W'(IN_W - 2 - k);
            end
        end
        if (m1_reg[IN_W-1]) begin
            sh2_next = '0;
        end
    end

    always_comb begin
        vec3_next.zero_xy = zxy2_reg;
        vec3_next.z_pos   = zp2_reg;
        vec3_next.xs      = x2_reg <<< sh2_reg;
        vec3_next.ys      = y2_reg <<< sh2_reg;
        vec3_next.zs      = z2_reg <<< sh2_reg;
    end

    assign px = $signed(vec3_reg.xs) * $signed(vec3_reg.xs);
    assign py = $signed(vec3_reg.ys) * $signed(vec3_reg.ys);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= vld_in;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg   <= x_in;
            y0_reg   <= y_in;
            z0_reg   <= z_in;
            x1_reg   <= x0_reg;
            y1_reg   <= y0_reg;
            z1_reg   <= z0_reg;
            m1_reg   <= m1_next;
            zxy1_reg <= (x0_reg == '0) && (y0_reg == '0);
            zp1_reg  <= !z0_reg[IN_W-1] && (z0_reg != '0);
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;
            zxy2_reg <= zxy1_reg;
            zp2_reg  <= zp1_reg;
            sh2_reg  <= sh2_next;
            vec3_reg <= vec3_next;
            vec4_reg <= vec3_reg;
            sqx4_reg <= $unsigned(px);
            sqy4_reg <= $unsigned(py);
            vec5_reg <= vec4_reg;
            sum5_reg <= sqx4_reg + sqy4_reg;
        end
    end

    assign vld_out = v5_reg;
    assign vec_out = vec5_reg;
    assign sum_out = sum5_reg;

endmodule

FILE: src/v2py_sqrt.sv
// Pipelined integer square root of the horizontal length squared, one root bit per stage.
// Depends on v2py_pkg.
module v2py_sqrt import v2py_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            vld_in,
    input  v2py_vec_t       vec_in,
    input  logic [SQ_W-1:0] sum_in,
    output logic            vld_out,
    output v2py_vec_t       vec_out,
    output logic [RT_W-1:0] h_out
);

    localparam int TW = SQ_W + 2;

    logic            vld_reg  [RT_W];
    v2py_vec_t       vec_reg  [RT_W];
    logic [SQ_W-1:0] rem_reg  [RT_W];
    logic [RT_W-1:0] root_reg [RT_W];

    for (genvar j = 0; j < RT_W; j++) begin : g_stage
        localparam int K = RT_W - 1 - j;

        logic            vin;
        v2py_vec_t       vecin;
        logic [SQ_W-1:0] rem_in, rem_next;
        logic [RT_W-1:0] root_in, root_next;
        logic [TW-1:0]   trial;
        logic            fits;

        if (j == 0) begin : g_first
            assign vin     = vld_in;
            assign vecin   = vec_in;
            assign rem_in  = sum_in;
            assign root_in = '0;
        end else begin : g_next
            assign vin     = vld_reg[j-1];
            assign vecin   = vec_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        always_comb begin
            trial     = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
            fits      = TW'(rem_in) >= trial;
            rem_next  = fits ? rem_in - trial[SQ_W-1:0] : rem_in;
            root_next = fits ? (root_in | (RT_W'(1) << K)) : root_in;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                vec_reg[j]  <= vecin;
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    assign vld_out = vld_reg[RT_W-1];
    assign vec_out = vec_reg[RT_W-1];
    assign h_out   = root_reg[RT_W-1];

endmodule

FILE: src/v2py_cordic.sv
// Twin vectoring CORDIC pipelines for yaw and pitch, one micro-rotation per stage.
// Depends on v2py_pkg.
module v2py_cordic import v2py_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            vld_in,
    input  v2py_vec_t       vec_in,
    input  logic [RT_W-1:0] h_in,
    output logic            vld_out,
    output v2py_cst_t       cst_out
);

    logic      vld_reg [STEPS];
    v2py_cst_t cst_reg [STEPS];
    v2py_cst_t cst_init;

    logic signed [CW-1:0] xa, yb;

    function automatic v2py_rot_t rotate(input v2py_rot_t r, input int unsigned i);
        v2py_rot_t n;
        n = r;
        if (!r.hold) begin
            if (!r.b[CW-1]) begin
                n.a   = r.a + ($signed(r.b) >>> i);
                n.b   = r.b - ($signed(r.a) >>> i);
                n.ang = r.ang + atan_q24(i);
            end else begin
                n.a   = r.a - ($signed(r.b) >>> i);
                n.b   = r.b + ($signed(r.a) >>> i);
                n.ang = r.ang - atan_q24(i);
            end
        end
        return n;
    endfunction

    // fold the left half plane onto the right one: negate and start at 180
    always_comb begin
        xa = CW'($signed(vec_in.xs)) <<< FRAC_SH;
        yb = CW'($signed(vec_in.ys)) <<< FRAC_SH;
        cst_init.zero_xy   = vec_in.zero_xy;
        cst_init.z_pos     = vec_in.z_pos;
        cst_init.yaw.hold  = (vec_in.ys == '0);
        cst_init.yaw.a     = vec_in.xs[IN_W-1] ? -xa : xa;
        cst_init.yaw.b     = vec_in.xs[IN_W-1] ? -yb : yb;
        cst_init.yaw.ang   = vec_in.xs[IN_W-1] ? HALF_TURN_Q24 : '0;
        cst_init.pitch.hold = (vec_in.zs == '0);
        cst_init.pitch.a    = CW'(h_in) <<< FRAC_SH;
        cst_init.pitch.b    = CW'($signed(vec_in.zs)) <<< FRAC_SH;
        cst_init.pitch.ang  = '0;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic      vin;
        v2py_cst_t cin, cst_next;

        if (i == 0) begin : g_first
            assign vin = vld_in;
            assign cin = cst_init;
        end else begin : g_next
            assign vin = vld_reg[i-1];
            assign cin = cst_reg[i-1];
        end

        always_comb begin
            cst_next       = cin;
            cst_next.yaw   = rotate(cin.yaw, i);
            cst_next.pitch = rotate(cin.pitch, i);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                cst_reg[i] <= cst_next;
            end
        end
    end

    assign vld_out = vld_reg[STEPS-1];
    assign cst_out = cst_reg[STEPS-1];

endmodule

FILE: src/v2py_out.sv
// Output stage: rounding to Q9.16 degrees, wrap into one turn, output register and skid beat.
// Depends on v2py_pkg.
module v2py_out import v2py_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 vld_in,
    input  v2py_cst_t            cst_in,
    output logic                 en,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic                   out_valid_reg, skid_valid_reg;
    logic [2*OUT_W-1:0]     out_reg, skid_reg;
    logic [2*OUT_W-1:0]     res_next;
    logic [OUT_W-1:0]       pitch_next, yaw_next;
    logic                   push, take;

    function automatic logic [OUT_W-1:0] to_q916(input logic signed [AW-1:0] ang);
        logic signed [AW-1:0]  r;
        logic signed [Q_W-1:0] q;
        r = ang + ROUND_HALF;
        q = Q_W'(r >>> RND_SH);
        if (q < 0) begin
            q = q + FULL_TURN_Q16;
        end else if (q >= FULL_TURN_Q16) begin
            q = q - FULL_TURN_Q16;
        end
        return q[OUT_W-1:0];
    endfunction

    always_comb begin
        if (cst_in.zero_xy) begin
            pitch_next = cst_in.z_pos ? RIGHT_Q16 : THREE_RIGHT_Q16;
            yaw_next   = '0;
        end else begin
            pitch_next = to_q916(cst_in.pitch.ang);
            yaw_next   = to_q916(cst_in.yaw.ang);
        end
        res_next = {yaw_next, pitch_next};
    end

    assign en   = !skid_valid_reg;
    assign push = vld_in && en;
    assign take = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= skid_valid_reg ? skid_reg : res_next;
        end else if (push) begin
            skid_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held with empty output register");

    a_angle_in_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (Q_W'(out_reg[OUT_W-1:0]) < FULL_TURN_Q16)
                       && (Q_W'(out_reg[2*OUT_W-1:OUT_W]) < FULL_TURN_Q16))
        else $error("angle outside one turn");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid beat lost while output stalled");
`endif

endmodule
